@@ rtl/dcrm_pkg.sv @@
// Shared types, register codes and reset constants of the damped comb reverb mixer.
`default_nettype none

package dcrm_pkg;

    // Default structural parameters.
    localparam int DEF_MAX_COMB_LENGTH = 4096;
    localparam int DEF_COMB_COUNT      = 4;
    localparam int DEF_SAMPLE_BITS     = 24;

    // Fixed field widths.
    localparam int GAIN_BITS      = 16;
    localparam int LEN_BITS       = 13;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING  = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WET      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_BASE = 4'd3;

    // Reset values: decay 0.72, damping 0.45 and wet 0.32 in Q0.16.
    localparam logic [GAIN_BITS-1:0] FEEDBACK_RESET = 16'd47186;
    localparam logic [GAIN_BITS-1:0] DAMPING_RESET  = 16'd29491;
    localparam logic [GAIN_BITS-1:0] WET_RESET      = 16'd20972;

    // Comb lengths of 27.7, 33.1, 41.1 and 47.3 ms at 48 kHz, then spares for wider builds.
    localparam logic [LEN_BITS-1:0] LENGTH_DEFAULTS [8] = '{
        13'd1329, 13'd1588, 13'd1972, 13'd2270,
        13'd2500, 13'd2700, 13'd2900, 13'd3100
    };

    // Unity and one half in Q0.16.
    localparam logic [GAIN_BITS:0] ONE_Q16  = 17'h10000;
    localparam int                 HALF_Q16 = 32768;

    // Gain registers as seen by the channel datapaths.
    typedef struct packed {
        logic [GAIN_BITS-1:0] feedback;
        logic [GAIN_BITS-1:0] damping;
        logic [GAIN_BITS-1:0] wet;
    } gains_t;

    // Step strobes from the sequencer to each channel datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic hit;
        logic mul_a;
        logic mul_b;
        logic damp;
        logic mul_c;
        logic wr;
        logic mul_wet;
        logic rnd_wet;
        logic div_start;
        logic emit;
    } chan_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/dcrm_if.sv @@
// Request channel interfaces of the damped comb reverb mixer: frames in, mixes out, config.
`default_nettype none

interface dcrm_in_if #(
    parameter int SAMPLE_BITS = dcrm_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] send_left;
    logic signed [SAMPLE_BITS-1:0] send_right;
    logic signed [SAMPLE_BITS-1:0] music_left;
    logic signed [SAMPLE_BITS-1:0] music_right;

    modport source (
        output valid, send_left, send_right, music_left, music_right,
        input  ready
    );
    modport sink (
        input  valid, send_left, send_right, music_left, music_right,
        output ready
    );
endinterface

interface dcrm_out_if #(
    parameter int SAMPLE_BITS = dcrm_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mixed_left;
    logic signed [SAMPLE_BITS-1:0] mixed_right;

    modport source (
        output valid, mixed_left, mixed_right,
        input  ready
    );
    modport sink (
        input  valid, mixed_left, mixed_right,
        output ready
    );
endinterface

interface dcrm_cfg_if;
    import dcrm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/damped_comb_reverb_mixer.sv @@
// Stereo damped comb reverb mixer: sequencer, configuration registers and two channels.
//
// Usage: stereo frames arrive as requests on din (send and music sample per side) and
// each gives one request on dout carrying the two mixed samples. Configuration writes
// go through cfg, which is always ready; index 0 is decay, 1 damping, 2 wet level and
// 3 onwards the comb lengths. Writes to other indexes are dropped. Write only while idle.
// One frame is in work at a time: the next frame is taken only once the result is
// registered and the sequencer is idle again. Per comb, the steps are the read of the
// line memory (one port per channel), the three damping and feedback multiplications
// with the damping state update before the last of them, and the write back. The
// wet-scaled comb total is divided by COMB_COUNT through a reciprocal multiplication.
// The result sits in an output register, so din takes the next frame while a result
// waits; if the receiver still stalls when the next result is due, the block holds it.
// Reset loads the default gains and lengths, zeroes positions and damping states and
// marks every comb line empty through a per-comb fill count; unwritten entries read as
// zero, so no clearing pass is needed and the block is ready at once.
`default_nettype none

module damped_comb_reverb_mixer #(
    parameter int MAX_COMB_LENGTH = dcrm_pkg::DEF_MAX_COMB_LENGTH,
    parameter int COMB_COUNT      = dcrm_pkg::DEF_COMB_COUNT,
    parameter int SAMPLE_BITS     = dcrm_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcrm_cfg_if.sink   cfg,
    dcrm_in_if.sink    din,
    dcrm_out_if.source dout
);
    import dcrm_pkg::*;

    localparam int AW     = $clog2(COMB_COUNT * MAX_COMB_LENGTH);
    localparam int KW     = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
    localparam int POS_W  = $clog2(MAX_COMB_LENGTH);
    localparam int FILL_W = POS_W + 1;
    localparam int LW     = (LEN_BITS > POS_W + 1) ? LEN_BITS : POS_W + 1;

    localparam logic [KW-1:0]             K_LAST  = KW'(COMB_COUNT - 1);
    localparam logic [LW-1:0]             LEN_MAX = LW'(MAX_COMB_LENGTH);
    localparam logic [LW-1:0]             LEN_ONE = LW'(1);
    localparam logic [CFG_INDEX_BITS:0]   LEN_END = (CFG_INDEX_BITS + 1)'(3 + COMB_COUNT);
    localparam logic [AW-1:0]             LINE_SPAN = AW'(MAX_COMB_LENGTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MULA,
        S_MULB,
        S_DAMP,
        S_MULC,
        S_WRITE,
        S_WET,
        S_RND,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [KW-1:0]      k_reg, k_next;
    logic               hit_reg, hit_next;
    logic [POS_W-1:0]   pos_reg [COMB_COUNT];
    logic [POS_W-1:0]   pos_next [COMB_COUNT];
    logic [FILL_W-1:0]  fill_reg [COMB_COUNT];
    logic [FILL_W-1:0]  fill_next [COMB_COUNT];
    logic               out_valid_reg, out_valid_next;

    gains_t             gains_reg;
    logic [LEN_BITS-1:0] len_reg [COMB_COUNT];

    chan_ctrl_t         ctrl;
    logic               accept;
    logic               emit;
    logic               done_l, done_r;
    logic [POS_W-1:0]   pos_cur;
    logic [FILL_W-1:0]  fill_cur;
    logic [LW-1:0]      len_raw;
    logic [LW-1:0]      len_eff;
    logic [LW-1:0]      pos_inc;
    logic               wrap;
    logic [AW-1:0]      addr;
    logic [CFG_INDEX_BITS-1:0] len_sel;

    // Configuration registers; a comb length keeps only the low LEN_BITS bits of the data.
    assign cfg.ready = 1'b1;
    assign len_sel   = cfg.index - REG_LEN_BASE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.feedback <= FEEDBACK_RESET;
            gains_reg.damping  <= DAMPING_RESET;
            gains_reg.wet      <= WET_RESET;
            for (int i = 0; i < COMB_COUNT; i++)
            begin
                len_reg[i] <= LENGTH_DEFAULTS[i];
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_FEEDBACK)
            begin
                gains_reg.feedback <= cfg.data;
            end
            else if (cfg.index == REG_DAMPING)
            begin
                gains_reg.damping <= cfg.data;
            end
            else if (cfg.index == REG_WET)
            begin
                gains_reg.wet <= cfg.data;
            end
            else if (cfg.index >= REG_LEN_BASE && {1'b0, cfg.index} < LEN_END)
            begin
                len_reg[len_sel[KW-1:0]] <= cfg.data[LEN_BITS-1:0];
            end
        end
    end

    // Current comb: effective length, wrap test and line address.
    assign pos_cur  = pos_reg[k_reg];
    assign fill_cur = fill_reg[k_reg];
    assign len_raw  = LW'(len_reg[k_reg]);
    assign len_eff  = (len_raw == '0) ? LEN_ONE : ((len_raw > LEN_MAX) ? LEN_MAX : len_raw);
    assign pos_inc  = LW'(pos_cur) + LEN_ONE;
    assign wrap     = (pos_inc >= len_eff);
    assign addr     = AW'(k_reg) * LINE_SPAN + AW'(pos_cur);

    // Handshakes.
    assign din.ready  = (state_reg == S_IDLE);
    assign accept     = din.valid && (state_reg == S_IDLE);
    assign emit       = (state_reg == S_OUT) && (!out_valid_reg || dout.ready);
    assign dout.valid = out_valid_reg;

    // Step strobes for both channels.
    always_comb
    begin
        ctrl      = '0;
        ctrl.load = accept;
        ctrl.hit  = hit_reg;
        case (state_reg)
            S_READ:   ctrl.rd        = 1'b1;
            S_MULA:   ctrl.mul_a     = 1'b1;
            S_MULB:   ctrl.mul_b     = 1'b1;
            S_DAMP:   ctrl.damp      = 1'b1;
            S_MULC:   ctrl.mul_c     = 1'b1;
            S_WRITE:  ctrl.wr        = 1'b1;
            S_WET:    ctrl.mul_wet   = 1'b1;
            S_RND:    ctrl.rnd_wet   = 1'b1;
            S_DSTART: ctrl.div_start = 1'b1;
            S_OUT:    ctrl.emit      = emit;
            default:  ctrl.load      = accept;
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;

        if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                hit_next   = ({1'b0, pos_cur} < fill_cur);
                state_next = S_MULA;
            end
            S_MULA:  state_next = S_MULB;
            S_MULB:  state_next = S_DAMP;
            S_DAMP:  state_next = S_MULC;
            S_MULC:  state_next = S_WRITE;
            S_WRITE:
            begin
                // Lines fill from position zero up, so one mark per comb covers them.
                if ({1'b0, pos_cur} == fill_cur)
                begin
                    fill_next[k_reg] = fill_cur + FILL_W'(1);
                end
                pos_next[k_reg] = wrap ? '0 : pos_inc[POS_W-1:0];
                if (k_reg == K_LAST)
                begin
                    state_next = S_WET;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_READ;
                end
            end
            S_WET:    state_next = S_RND;
            S_RND:    state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (done_l && done_r)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer state, comb positions, fill marks and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COMB_COUNT; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
        end
    end

    // Left and right datapaths share positions and strobes.
    dcrm_channel #(
        .MAX_COMB_LENGTH (MAX_COMB_LENGTH),
        .COMB_COUNT      (COMB_COUNT),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .AW              (AW),
        .KW              (KW)
    ) u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .gains    (gains_reg),
        .comb     (k_reg),
        .addr     (addr),
        .send_in  (din.send_left),
        .music_in (din.music_left),
        .mixed    (dout.mixed_left),
        .div_done (done_l)
    );

    dcrm_channel #(
        .MAX_COMB_LENGTH (MAX_COMB_LENGTH),
        .COMB_COUNT      (COMB_COUNT),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .AW              (AW),
        .KW              (KW)
    ) u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .gains    (gains_reg),
        .comb     (k_reg),
        .addr     (addr),
        .send_in  (din.send_right),
        .music_in (din.music_right),
        .mixed    (dout.mixed_right),
        .div_done (done_r)
    );

endmodule

`default_nettype wire

@@ rtl/dcrm_line_mem.sv @@
// Single-port synchronous RAM holding the comb delay lines of one channel.
`default_nettype none

module dcrm_line_mem #(
    parameter int WIDTH = dcrm_pkg::DEF_SAMPLE_BITS,
    parameter int DEPTH = dcrm_pkg::DEF_COMB_COUNT * dcrm_pkg::DEF_MAX_COMB_LENGTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access a cycle; read data appears the cycle after the read strobe.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dcrm_div_const.sv @@
// Signed floor division by a small constant through a reciprocal multiplication.
`default_nettype none

module dcrm_div_const #(
    parameter int WIDTH   = 29,
    parameter int DIVISOR = dcrm_pkg::DEF_COMB_COUNT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [WIDTH-1:0] dividend,
    output logic signed      [WIDTH-1:0] quotient,
    output logic                         done
);

    // With the shift widened by clog2(DIVISOR) bits, the rounded-up reciprocal gives
    // the exact floor quotient for every magnitude below 2**WIDTH.
    localparam int SHIFT  = WIDTH + $clog2(DIVISOR);
    localparam int PROD_W = SHIFT + WIDTH;

    localparam logic [WIDTH-1:0] BIAS_V = WIDTH'(DIVISOR - 1);
    localparam logic [WIDTH:0]   RECIP  =
        (WIDTH + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [WIDTH-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    mul_reg;
    logic                    fin_reg;
    logic                    done_reg;
    logic signed [WIDTH-1:0] quot_reg;

    logic [WIDTH-1:0]        mag_in;
    logic [WIDTH-1:0]        q_mag;

    // A negative dividend is floored through its biased magnitude.
    assign mag_in = dividend[WIDTH-1] ? (BIAS_V - $unsigned(dividend)) : $unsigned(dividend);
    assign q_mag  = prod_reg[PROD_W-1:SHIFT];

    // Stage flags: magnitude, product, then the signed quotient.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= start;
            fin_reg  <= mul_reg;
            done_reg <= fin_reg;
        end
    end

    // Reciprocal multiplication; the operands are WIDTH by WIDTH+1 bits wide.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag_in;
            neg_reg <= dividend[WIDTH-1];
        end
        if (mul_reg)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
        end
        if (fin_reg)
        begin
            quot_reg <= neg_reg ? -$signed(q_mag) : $signed(q_mag);
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

@@ rtl/dcrm_channel.sv @@
// Datapath of one channel: comb line memory, damping states, comb total and wet mix.
`default_nettype none

module dcrm_channel #(
    parameter int MAX_COMB_LENGTH = dcrm_pkg::DEF_MAX_COMB_LENGTH,
    parameter int COMB_COUNT      = dcrm_pkg::DEF_COMB_COUNT,
    parameter int SAMPLE_BITS     = dcrm_pkg::DEF_SAMPLE_BITS,
    parameter int AW              = $clog2(COMB_COUNT * MAX_COMB_LENGTH),
    parameter int KW              = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dcrm_pkg::chan_ctrl_t          ctrl,
    input  wire dcrm_pkg::gains_t              gains,
    input  wire logic [KW-1:0]                 comb,
    input  wire logic [AW-1:0]                 addr,
    input  wire logic signed [SAMPLE_BITS-1:0] send_in,
    input  wire logic signed [SAMPLE_BITS-1:0] music_in,
    output logic signed [SAMPLE_BITS-1:0]      mixed,
    output logic                               div_done
);
    import dcrm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PA_W  = SB + 18;
    localparam int PB_W  = SB + 17;
    localparam int MIX_W = SB + 19;
    localparam int PC_W  = SB + 18;
    localparam int TOT_W = SB + $clog2(COMB_COUNT) + 1;
    localparam int PW_W  = TOT_W + 17;
    localparam int WS_W  = TOT_W + 18;
    localparam int Q_W   = TOT_W + 2;
    localparam int SAT_W = SB + 8;

    localparam logic signed [SAT_W-1:0] S_MAX = SAT_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] S_MIN = -S_MAX - SAT_W'(1);
    localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(HALF_Q16);
    localparam logic signed [PC_W-1:0]  PC_HALF  = PC_W'(HALF_Q16);
    localparam logic signed [WS_W-1:0]  WET_BIAS = WS_W'(COMB_COUNT * HALF_Q16);

    // Clamp to the signed sample range.
    function automatic logic signed [SB-1:0] sat_s(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        c = v;
        if (v > S_MAX)
        begin
            c = S_MAX;
        end
        else if (v < S_MIN)
        begin
            c = S_MIN;
        end
        return c[SB-1:0];
    endfunction

    logic signed [SB-1:0]    send_reg;
    logic signed [SB-1:0]    music_reg;
    logic signed [SB-1:0]    lp_reg [COMB_COUNT];
    logic signed [PA_W-1:0]  prod_a_reg;
    logic signed [PB_W-1:0]  prod_b_reg;
    logic signed [PC_W-1:0]  prod_c_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic signed [PW_W-1:0]  prod_w_reg;
    logic signed [Q_W-1:0]   q1_reg;
    logic signed [SB-1:0]    mixed_reg;

    logic [SB-1:0]           rdata;
    logic [SB-1:0]           wdata;
    logic signed [SB-1:0]    d;
    logic signed [SB-1:0]    lp_cur;
    logic [GAIN_BITS:0]      damp_c;
    logic signed [MIX_W-1:0] mix_sum;
    logic signed [SB+2:0]    lp_rnd;
    logic signed [PC_W-1:0]  fb_sum;
    logic signed [SB+1:0]    fb_rnd;
    logic signed [SAT_W-1:0] wr_sum;
    logic signed [WS_W-1:0]  wet_sum;
    logic signed [Q_W-1:0]   quot;
    logic signed [SAT_W-1:0] out_sum;

    dcrm_line_mem #(
        .WIDTH (SB),
        .DEPTH (COMB_COUNT * MAX_COMB_LENGTH),
        .AW    (AW)
    ) u_line_mem (
        .clk   (clk),
        .rd_en (ctrl.rd),
        .wr_en (ctrl.wr),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    dcrm_div_const #(
        .WIDTH   (Q_W),
        .DIVISOR (COMB_COUNT)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (q1_reg),
        .quotient (quot),
        .done     (div_done)
    );

    // Entries at or beyond the fill mark of a comb read as the cleared value.
    assign d      = ctrl.hit ? $signed(rdata) : '0;
    assign lp_cur = lp_reg[comb];
    assign damp_c = ONE_Q16 - {1'b0, gains.damping};

    // Damping state: round half up of the two-product mix, then clamp.
    assign mix_sum = MIX_W'(prod_a_reg) + MIX_W'(prod_b_reg) + MIX_HALF;
    assign lp_rnd  = mix_sum[MIX_W-1:16];

    // Line write: send plus the rounded feedback term, clamped.
    assign fb_sum = prod_c_reg + PC_HALF;
    assign fb_rnd = fb_sum[PC_W-1:16];
    assign wr_sum = SAT_W'(send_reg) + SAT_W'(fb_rnd);
    assign wdata  = sat_s(wr_sum);

    // Wet term: the bias rounds the Q0.16 scaling and comb average together.
    assign wet_sum = WS_W'(prod_w_reg) + WET_BIAS;
    assign out_sum = SAT_W'(music_reg) + SAT_W'(quot);

    // Damping states are cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COMB_COUNT; i++)
            begin
                lp_reg[i] <= '0;
            end
        end
        else if (ctrl.damp)
        begin
            lp_reg[comb] <= sat_s(SAT_W'(lp_rnd));
        end
    end

    // Products and running sums, one multiplication per step.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            send_reg  <= send_in;
            music_reg <= music_in;
            total_reg <= '0;
        end
        if (ctrl.mul_a)
        begin
            prod_a_reg <= d * $signed({1'b0, damp_c});
            total_reg  <= total_reg + TOT_W'(d);
        end
        if (ctrl.mul_b)
        begin
            prod_b_reg <= lp_cur * $signed({1'b0, gains.damping});
        end
        if (ctrl.mul_c)
        begin
            prod_c_reg <= lp_cur * $signed({1'b0, gains.feedback});
        end
        if (ctrl.mul_wet)
        begin
            prod_w_reg <= total_reg * $signed({1'b0, gains.wet});
        end
        if (ctrl.rnd_wet)
        begin
            q1_reg <= wet_sum[WS_W-1:16];
        end
        if (ctrl.emit)
        begin
            mixed_reg <= sat_s(out_sum);
        end
    end

    assign mixed = mixed_reg;

endmodule

`default_nettype wire
